[hw/rtl/sfcd_pkg.sv]
// Shared types, codes and constants for the status frame check and decode block.
// No dependencies; used by the decoder and the top level.
`timescale 1ns / 1ps

package sfcd_pkg;

  localparam int unsigned PayloadLen = 10;
  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned CfgDataW   = 32;

  localparam logic [7:0] MinFrame    = 8'd12;
  localparam logic [7:0] LenOffset   = 8'd3;
  localparam logic [7:0] FirstData   = 8'd2;
  localparam logic [7:0] RoomPos     = 8'd18;
  localparam logic [7:0] OutdoorPos  = 8'd19;
  localparam logic [7:0] CountMax    = 8'hFF;

  // register select, taken from paddr[2]
  localparam logic RegCtrlHdr = 1'b0;
  localparam logic RegPollHdr = 1'b1;

  localparam logic [2:0] STAT_POLL_OK  = 3'd0;
  localparam logic [2:0] STAT_OTHER_OK = 3'd1;
  localparam logic [2:0] STAT_SHORT    = 3'd2;
  localparam logic [2:0] STAT_BAD_HDR  = 3'd3;
  localparam logic [2:0] STAT_LEN_ERR  = 3'd4;
  localparam logic [2:0] STAT_SUM_ERR  = 3'd5;

  localparam logic [2:0] MODE_OFF  = 3'd0;
  localparam logic [2:0] MODE_AUTO = 3'd1;
  localparam logic [2:0] MODE_COOL = 3'd2;
  localparam logic [2:0] MODE_HEAT = 3'd3;
  localparam logic [2:0] MODE_DRY  = 3'd4;
  localparam logic [2:0] MODE_FAN  = 3'd5;

  localparam logic [2:0] FAN_AUTO    = 3'd0;
  localparam logic [2:0] FAN_UNKNOWN = 3'd6;

  localparam logic [2:0] SWING_AUTO        = 3'd0;
  localparam logic [2:0] SWING_UNSUPPORTED = 3'd6;
  localparam logic [2:0] SWING_UNKNOWN     = 3'd7;

  localparam logic [1:0] PRESET_NORMAL   = 2'd0;
  localparam logic [1:0] PRESET_POWERFUL = 2'd1;
  localparam logic [1:0] PRESET_QUIET    = 2'd2;

  localparam logic [7:0] FanAutoByte = 8'hA0;
  localparam logic [7:0] EcoByte     = 8'h40;
  localparam logic [7:0] MildDryByte = 8'h7F;
  localparam logic [3:0] NanoexNib   = 4'h4;

  // Frame as it stands once the current byte is folded in
  typedef struct packed {
    logic [7:0]                      header;
    logic [7:0]                      length;
    logic [7:0]                      count;
    logic                            ovf;
    logic [7:0]                      sum;
    logic [PayloadLen-1:0][7:0]      payload;
    logic [7:0]                      room;
    logic [7:0]                      outdoor;
  } frame_t;

  typedef struct packed {
    logic [2:0]        frame_status;
    logic [2:0]        mode_code;
    logic [2:0]        fan_code;
    logic [2:0]        vertical_swing;
    logic [2:0]        horizontal_swing;
    logic [1:0]        preset_code;
    logic              nanoex_on;
    logic              eco_on;
    logic              mild_dry_on;
    logic signed [7:0] target_temp;
    logic signed [7:0] room_temp;
    logic signed [7:0] outdoor_temp;
  } result_t;

endpackage

[hw/rtl/sfcd_in_if.sv]
// Request channel for received frame bytes: valid/ready plus byte and end flag.
// Depends on nothing.
`timescale 1ns / 1ps

interface sfcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, rx_byte, frame_end, input ready);
  modport sink   (input valid, rx_byte, frame_end, output ready);
endinterface

[hw/rtl/sfcd_out_if.sv]
// Result channel: frame status and decoded climate fields, valid/ready.
// Depends on nothing.
`timescale 1ns / 1ps

interface sfcd_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        frame_status;
  logic [2:0]        mode_code;
  logic [2:0]        fan_code;
  logic [2:0]        vertical_swing;
  logic [2:0]        horizontal_swing;
  logic [1:0]        preset_code;
  logic              nanoex_on;
  logic              eco_on;
  logic              mild_dry_on;
  logic signed [7:0] target_temp;
  logic signed [7:0] room_temp;
  logic signed [7:0] outdoor_temp;

  modport source (output valid, frame_status, mode_code, fan_code, vertical_swing,
                  horizontal_swing, preset_code, nanoex_on, eco_on, mild_dry_on,
                  target_temp, room_temp, outdoor_temp, input ready);
  modport sink   (input valid, frame_status, mode_code, fan_code, vertical_swing,
                  horizontal_swing, preset_code, nanoex_on, eco_on, mild_dry_on,
                  target_temp, room_temp, outdoor_temp, output ready);
endinterface

[hw/rtl/sfcd_decode.sv]
// Frame checks and poll-field decode, purely combinational.
// Depends on sfcd_pkg.
`timescale 1ns / 1ps

module sfcd_decode (
  input  sfcd_pkg::frame_t  frame,
  input  logic [7:0]        ctrl_hdr,
  input  logic [7:0]        poll_hdr,
  output sfcd_pkg::result_t res
);

  logic       too_short;
  logic       hdr_ok;
  logic       len_bad;
  logic [2:0] status;
  logic [7:0] d0, d3, d4, d5;

  assign d0 = frame.payload[0];
  assign d3 = frame.payload[3];
  assign d4 = frame.payload[4];
  assign d5 = frame.payload[5];

  assign too_short = !frame.ovf && (frame.count < sfcd_pkg::MinFrame);
  assign hdr_ok    = (frame.header == ctrl_hdr) || (frame.header == poll_hdr);
  // count is at least 12 here, so count - 3 never wraps
  assign len_bad   = frame.ovf || (frame.length != (frame.count - sfcd_pkg::LenOffset));

  always_comb begin
    if (too_short) begin
      status = sfcd_pkg::STAT_SHORT;
    end else if (!hdr_ok) begin
      status = sfcd_pkg::STAT_BAD_HDR;
    end else if (len_bad) begin
      status = sfcd_pkg::STAT_LEN_ERR;
    end else if (frame.sum != 8'd0) begin
      status = sfcd_pkg::STAT_SUM_ERR;
    end else if (frame.header == poll_hdr) begin
      status = sfcd_pkg::STAT_POLL_OK;
    end else begin
      status = sfcd_pkg::STAT_OTHER_OK;
    end
  end

  always_comb begin
    res = '0;
    res.frame_status = status;
    if (status == sfcd_pkg::STAT_POLL_OK) begin
      if (d0[3:0] == 4'h0) begin
        res.mode_code = sfcd_pkg::MODE_OFF;
      end else begin
        case (d0[7:4])
          4'h0:    res.mode_code = sfcd_pkg::MODE_AUTO;
          4'h3:    res.mode_code = sfcd_pkg::MODE_COOL;
          4'h4:    res.mode_code = sfcd_pkg::MODE_HEAT;
          4'h2:    res.mode_code = sfcd_pkg::MODE_DRY;
          4'h6:    res.mode_code = sfcd_pkg::MODE_FAN;
          default: res.mode_code = sfcd_pkg::MODE_OFF;
        endcase
      end

      // speeds 1..5 sit at 0x30..0x70
      if (d3 == sfcd_pkg::FanAutoByte) begin
        res.fan_code = sfcd_pkg::FAN_AUTO;
      end else if (d3[3:0] == 4'h0 && d3[7:4] inside {[4'h3:4'h7]}) begin
        res.fan_code = d3[6:4] - 3'd2;
      end else begin
        res.fan_code = sfcd_pkg::FAN_UNKNOWN;
      end

      if (d4[7:4] == 4'hF) begin
        res.vertical_swing = sfcd_pkg::SWING_AUTO;
      end else if (d4[7:4] inside {[4'h1:4'h5]}) begin
        res.vertical_swing = d4[6:4];
      end else if (d4[7:4] == 4'h0) begin
        res.vertical_swing = sfcd_pkg::SWING_UNSUPPORTED;
      end else begin
        res.vertical_swing = sfcd_pkg::SWING_UNKNOWN;
      end

      case (d4[3:0])
        4'hD:    res.horizontal_swing = sfcd_pkg::SWING_AUTO;
        4'h9:    res.horizontal_swing = 3'd1;
        4'hA:    res.horizontal_swing = 3'd2;
        4'h6:    res.horizontal_swing = 3'd3;
        4'hB:    res.horizontal_swing = 3'd4;
        4'hC:    res.horizontal_swing = 3'd5;
        4'h0:    res.horizontal_swing = sfcd_pkg::SWING_UNSUPPORTED;
        default: res.horizontal_swing = sfcd_pkg::SWING_UNKNOWN;
      endcase

      case (d5[3:0])
        4'h2:    res.preset_code = sfcd_pkg::PRESET_POWERFUL;
        4'h4:    res.preset_code = sfcd_pkg::PRESET_QUIET;
        default: res.preset_code = sfcd_pkg::PRESET_NORMAL;
      endcase

      res.nanoex_on    = (d5[7:4] == sfcd_pkg::NanoexNib);
      res.eco_on       = (frame.payload[8] == sfcd_pkg::EcoByte);
      res.mild_dry_on  = (frame.payload[2] == sfcd_pkg::MildDryByte);
      res.target_temp  = frame.payload[1];
      res.room_temp    = frame.room;
      res.outdoor_temp = frame.outdoor;
    end
  end

endmodule

[hw/rtl/status_frame_check_and_decode.sv]
// Top level: byte capture, frame state, APB header registers and result register.
// Depends on sfcd_pkg, sfcd_in_if, sfcd_out_if and sfcd_decode.
//
//   port     dir   role
//   in_ch    sink  one received byte per request, frame_end on the last
//   out_ch   src   one result per frame (status plus decoded poll fields)
//   psel..   APB   control hdr at 0x0, poll hdr at 0x4
//
// One byte per cycle while no result waits. The last byte of a frame is checked
// and decoded in the cycle it is accepted; out_ch shows its result the next cycle.
// The result register frees as it is taken, so bytes keep flowing while
// out_ch.ready is high; if a result waits, in_ch.ready drops.
// Sync active-low reset clears out_valid, headers and frame state except payload.
`timescale 1ns / 1ps

module status_frame_check_and_decode (
  input  logic                              clk,
  input  logic                              rst_n,
  sfcd_in_if.sink                           in_ch,
  sfcd_out_if.source                        out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sfcd_pkg::CfgAddrW-1:0]     paddr,
  input  logic [sfcd_pkg::CfgDataW-1:0]     pwdata,
  output logic [sfcd_pkg::CfgDataW-1:0]     prdata,
  output logic                              pready
);

  logic [7:0] ctrl_hdr_r, poll_hdr_r;
  logic [7:0] count_r, sum_r, header_r, length_r, room_r, outdoor_r;
  logic       ovf_r;
  logic [sfcd_pkg::PayloadLen-1:0][7:0] payload_r;

  logic                 out_valid_r, out_valid_nxt;
  sfcd_pkg::result_t    out_res_r;
  sfcd_pkg::result_t    dec_res;
  sfcd_pkg::frame_t     frame_nxt;

  logic       in_acc, cap, cfg_wr;
  logic [7:0] b;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == sfcd_pkg::RegPollHdr) ? {24'd0, poll_hdr_r} : {24'd0, ctrl_hdr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_hdr_r <= 8'd0;
      poll_hdr_r <= 8'd0;
    end else if (cfg_wr) begin
      if (paddr[2] == sfcd_pkg::RegPollHdr) begin
        poll_hdr_r <= pwdata[7:0];
      end else begin
        ctrl_hdr_r <= pwdata[7:0];
      end
    end
  end

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign cap         = in_acc && !ovf_r;

  // frame state with the current byte folded in
  always_comb begin
    frame_nxt.header  = (cap && count_r == 8'd0) ? b : header_r;
    frame_nxt.length  = (cap && count_r == 8'd1) ? b : length_r;
    frame_nxt.room    = (cap && count_r == sfcd_pkg::RoomPos) ? b : room_r;
    frame_nxt.outdoor = (cap && count_r == sfcd_pkg::OutdoorPos) ? b : outdoor_r;
    for (int k = 0; k < sfcd_pkg::PayloadLen; k++) begin
      frame_nxt.payload[k] = (cap && count_r == sfcd_pkg::FirstData + 8'(k)) ? b
                                                                               : payload_r[k];
    end
    frame_nxt.sum   = in_acc ? sum_r + b : sum_r;
    frame_nxt.ovf   = ovf_r || (in_acc && count_r == sfcd_pkg::CountMax);
    frame_nxt.count = (in_acc && count_r != sfcd_pkg::CountMax) ? count_r + 8'd1 : count_r;
  end

  sfcd_decode u_decode (
    .frame    (frame_nxt),
    .ctrl_hdr (ctrl_hdr_r),
    .poll_hdr (poll_hdr_r),
    .res      (dec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= 8'd0;
      ovf_r     <= 1'b0;
      sum_r     <= 8'd0;
      header_r  <= 8'd0;
      length_r  <= 8'd0;
      room_r    <= 8'd0;
      outdoor_r <= 8'd0;
    end else if (in_acc) begin
      if (in_ch.frame_end) begin
        count_r   <= 8'd0;
        ovf_r     <= 1'b0;
        sum_r     <= 8'd0;
        header_r  <= 8'd0;
        length_r  <= 8'd0;
        room_r    <= 8'd0;
        outdoor_r <= 8'd0;
      end else begin
        count_r   <= frame_nxt.count;
        ovf_r     <= frame_nxt.ovf;
        sum_r     <= frame_nxt.sum;
        header_r  <= frame_nxt.header;
        length_r  <= frame_nxt.length;
        room_r    <= frame_nxt.room;
        outdoor_r <= frame_nxt.outdoor;
      end
    end
  end

  // payload needs no reset: a decoded frame always wrote every slot it reads
  always_ff @(posedge clk) begin
    payload_r <= frame_nxt.payload;
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (in_acc && in_ch.frame_end) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.frame_end) begin
      out_res_r <= dec_res;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.frame_status     = out_res_r.frame_status;
  assign out_ch.mode_code        = out_res_r.mode_code;
  assign out_ch.fan_code         = out_res_r.fan_code;
  assign out_ch.vertical_swing   = out_res_r.vertical_swing;
  assign out_ch.horizontal_swing = out_res_r.horizontal_swing;
  assign out_ch.preset_code      = out_res_r.preset_code;
  assign out_ch.nanoex_on        = out_res_r.nanoex_on;
  assign out_ch.eco_on           = out_res_r.eco_on;
  assign out_ch.mild_dry_on      = out_res_r.mild_dry_on;
  assign out_ch.target_temp      = out_res_r.target_temp;
  assign out_ch.room_temp        = out_res_r.room_temp;
  assign out_ch.outdoor_temp     = out_res_r.outdoor_temp;

  a_ovf_holds_max : assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> count_r == sfcd_pkg::CountMax)
    else $error("overflow mark set without saturated count");

  a_frame_clears : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.frame_end |=> count_r == 8'd0 && !ovf_r && sum_r == 8'd0)
    else $error("frame state not cleared after last byte");

  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.frame_end |=> out_valid_r)
    else $error("no result after last byte");

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("pending result could be overwritten");

  a_fields_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.frame_status != sfcd_pkg::STAT_POLL_OK
      |-> out_res_r[40:0] == 41'd0)
    else $error("non-poll result carries decoded fields");

endmodule
